// ----- sv/gvq_pkg.sv -----
// Package for the grid vorticity / Q stencil: shared widths, codes and the
// configuration register struct. No dependencies.
`default_nettype none
package gvq_pkg;

	localparam int IDX_W      = 5;
	localparam int VEL_W      = 16;
	localparam int DIM_W      = 6;
	localparam int INV_W      = 16;
	localparam int VORT_W     = 32;
	localparam int Q_W        = 48;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;
	localparam int KIND_W     = 2;

	localparam logic CMD_WR = 1'b0;

	localparam logic [KIND_W-1:0] KIND_WR  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_BRD = 2'd1;
	localparam logic [KIND_W-1:0] KIND_QRY = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_DIM_X = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DIM_Y = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DIM_Z = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_INV_X = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_INV_Y = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_INV_Z = 3'd5;

	localparam logic [DIM_W-1:0] DIM_RST = 6'd32;
	localparam logic [INV_W-1:0] INV_RST = 16'd256;

	typedef struct packed {
		logic [DIM_W-1:0] dim_x;
		logic [DIM_W-1:0] dim_y;
		logic [DIM_W-1:0] dim_z;
		logic [INV_W-1:0] inv_x;
		logic [INV_W-1:0] inv_y;
		logic [INV_W-1:0] inv_z;
	} cfg_t;

endpackage
`default_nettype wire

// ----- sv/grid_vorticity_q_stencil_top.sv -----
// Grid vorticity / Q stencil top: config registers, front end, queue, back end.
// An interior query reads seven points from the single-port store, one per cycle
// while out_stall does not hold the back end; writes and border queries read none.
// A query result passes six stages and a 32-stage root before the output register.
// Reset clears control state and loads dims of 32 and spacings of 1.0; the
// velocity store is undefined until written. Depends on gvq_pkg and submodules.
`default_nettype none
module grid_vorticity_q_stencil_top #(
	parameter int GRID_SIDE = 32,
	parameter int VEL_BITS  = 16
) (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire                                  cfg_wr_en,
	input  wire  [gvq_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  wire  [gvq_pkg::CFG_DATA_W-1:0]       cfg_data,
	input  wire                                  in_valid,
	output logic                                 in_stall,
	input  wire                                  cmd,
	input  wire  [gvq_pkg::IDX_W-1:0]            x_index,
	input  wire  [gvq_pkg::IDX_W-1:0]            y_index,
	input  wire  [gvq_pkg::IDX_W-1:0]            z_index,
	input  wire  signed [gvq_pkg::VEL_W-1:0]     vel_x,
	input  wire  signed [gvq_pkg::VEL_W-1:0]     vel_y,
	input  wire  signed [gvq_pkg::VEL_W-1:0]     vel_z,
	output logic                                 out_valid,
	input  wire                                  out_stall,
	output logic                                 at_border,
	output logic [gvq_pkg::VORT_W-1:0]           vorticity,
	output logic signed [gvq_pkg::Q_W-1:0]       q_value
);

	localparam int EW = gvq_pkg::KIND_W + $clog2(GRID_SIDE * GRID_SIDE * GRID_SIDE) +
	                    3 * VEL_BITS;

	gvq_pkg::cfg_t cfg_q;
	logic          push, fifo_full, head_valid, pop;
	logic [EW-1:0] push_data, head_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.dim_x <= gvq_pkg::DIM_RST;
			cfg_q.dim_y <= gvq_pkg::DIM_RST;
			cfg_q.dim_z <= gvq_pkg::DIM_RST;
			cfg_q.inv_x <= gvq_pkg::INV_RST;
			cfg_q.inv_y <= gvq_pkg::INV_RST;
			cfg_q.inv_z <= gvq_pkg::INV_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				gvq_pkg::REG_DIM_X: cfg_q.dim_x <= cfg_data[gvq_pkg::DIM_W-1:0];
				gvq_pkg::REG_DIM_Y: cfg_q.dim_y <= cfg_data[gvq_pkg::DIM_W-1:0];
				gvq_pkg::REG_DIM_Z: cfg_q.dim_z <= cfg_data[gvq_pkg::DIM_W-1:0];
				gvq_pkg::REG_INV_X: cfg_q.inv_x <= cfg_data;
				gvq_pkg::REG_INV_Y: cfg_q.inv_y <= cfg_data;
				gvq_pkg::REG_INV_Z: cfg_q.inv_z <= cfg_data;
				default: ;
			endcase
		end
	end

	gvq_front #(
		.GRID_SIDE(GRID_SIDE),
		.VEL_BITS (VEL_BITS)
	) u_front (
		.cfg      (cfg_q),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.cmd      (cmd),
		.x_index  (x_index),
		.y_index  (y_index),
		.z_index  (z_index),
		.vel_x    (vel_x),
		.vel_y    (vel_y),
		.vel_z    (vel_z),
		.fifo_full(fifo_full),
		.push     (push),
		.push_data(push_data)
	);

	gvq_fifo #(
		.WIDTH(EW),
		.DEPTH(4)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (fifo_full),
		.head_valid(head_valid),
		.head_data (head_data),
		.pop       (pop)
	);

	gvq_back #(
		.GRID_SIDE(GRID_SIDE),
		.VEL_BITS (VEL_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.head_valid(head_valid),
		.head_data (head_data),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.at_border (at_border),
		.vorticity (vorticity),
		.q_value   (q_value)
	);

endmodule
`default_nettype wire

// ----- sv/gvq_front.sv -----
// Front end: accepts input words, classifies them (write, border query,
// interior query) and forms the store address. Depends on gvq_pkg.
`default_nettype none
module gvq_front #(
	parameter int GRID_SIDE = 32,
	parameter int VEL_BITS  = 16
) (
	input  wire gvq_pkg::cfg_t                 cfg,
	input  wire                                in_valid,
	output logic                               in_stall,
	input  wire                                cmd,
	input  wire  [gvq_pkg::IDX_W-1:0]          x_index,
	input  wire  [gvq_pkg::IDX_W-1:0]          y_index,
	input  wire  [gvq_pkg::IDX_W-1:0]          z_index,
	input  wire  signed [gvq_pkg::VEL_W-1:0]   vel_x,
	input  wire  signed [gvq_pkg::VEL_W-1:0]   vel_y,
	input  wire  signed [gvq_pkg::VEL_W-1:0]   vel_z,
	input  wire                                fifo_full,
	output logic                               push,
	output logic [gvq_pkg::KIND_W+$clog2(GRID_SIDE*GRID_SIDE*GRID_SIDE)+3*VEL_BITS-1:0] push_data
);

	localparam int G  = GRID_SIDE;
	localparam int VB = VEL_BITS;
	localparam int AW = $clog2(G * G * G);
	localparam int GL = $clog2(G + 1);
	localparam int LW = ((GL > gvq_pkg::DIM_W) ? GL : gvq_pkg::DIM_W) + 1;

	logic [LW-1:0] gv, dx, dy, dz, px, py, pz;
	logic          brd, oob;
	logic [AW-1:0] addr;
	logic [gvq_pkg::KIND_W-1:0] kind;
	logic signed [VB-1:0] vx, vy, vz;

	always_comb begin
		gv = LW'(G);
		px = LW'(x_index);
		py = LW'(y_index);
		pz = LW'(z_index);
		dx = (LW'(cfg.dim_x) > gv) ? gv : LW'(cfg.dim_x);
		dy = (LW'(cfg.dim_y) > gv) ? gv : LW'(cfg.dim_y);
		dz = (LW'(cfg.dim_z) > gv) ? gv : LW'(cfg.dim_z);
		brd = (px == '0) || (px + LW'(1) >= dx) ||
		      (py == '0) || (py + LW'(1) >= dy) ||
		      (pz == '0) || (pz + LW'(1) >= dz);
		oob = (px >= gv) || (py >= gv) || (pz >= gv);
		addr = AW'(x_index) + AW'(G) * (AW'(y_index) + AW'(G) * AW'(z_index));
		vx = VB'(vel_x);
		vy = VB'(vel_y);
		vz = VB'(vel_z);
		if (cmd == gvq_pkg::CMD_WR) begin
			kind = gvq_pkg::KIND_WR;
		end else if (brd) begin
			kind = gvq_pkg::KIND_BRD;
		end else begin
			kind = gvq_pkg::KIND_QRY;
		end
	end

	// drop writes outside the store
	assign in_stall  = fifo_full;
	assign push      = in_valid && !fifo_full && !((cmd == gvq_pkg::CMD_WR) && oob);
	assign push_data = {kind, addr, vz, vy, vx};

endmodule
`default_nettype wire

// ----- sv/gvq_fifo.sv -----
// Short word queue between the front end and the back end.
// Register based; no package dependencies.
`default_nettype none
module gvq_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              push,
	input  wire  [WIDTH-1:0] push_data,
	output logic             full,
	output logic             head_valid,
	output logic [WIDTH-1:0] head_data,
	input  wire              pop
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_q, rd_q;
	logic [CW-1:0]    cnt_q;
	logic             do_pop;

	assign full       = (cnt_q == CW'(DEPTH));
	assign head_valid = (cnt_q != '0);
	assign head_data  = mem_q[rd_q];
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
			end
			if (do_pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
			end
			if (push && !do_pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (!push && do_pop) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

endmodule
`default_nettype wire

// ----- sv/gvq_sqrt.sv -----
// Pipelined integer square root of two 64-bit words, one root bit per stage,
// with a tag that travels alongside. No package dependencies.
`default_nettype none
module gvq_sqrt #(
	parameter int TAG_W = 1
) (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              adv,
	input  wire              in_valid,
	input  wire  [63:0]      in_a,
	input  wire  [63:0]      in_b,
	input  wire  [TAG_W-1:0] in_tag,
	output logic             out_valid,
	output logic [31:0]      out_ra,
	output logic [31:0]      out_rb,
	output logic [TAG_W-1:0] out_tag
);

	localparam int N = 32;

	typedef struct packed {
		logic [63:0] rad;
		logic [33:0] rem;
		logic [31:0] root;
	} sq_t;

	function automatic sq_t sqrt_step(sq_t s);
		sq_t         r;
		logic [35:0] r2;
		logic [35:0] trial;
		r2    = {s.rem, s.rad[63:62]};
		trial = {2'b00, s.root, 2'b01};
		r.rad = {s.rad[61:0], 2'b00};
		if (r2 >= trial) begin
			r.rem  = 34'(r2 - trial);
			r.root = {s.root[30:0], 1'b1};
		end else begin
			r.rem  = r2[33:0];
			r.root = {s.root[30:0], 1'b0};
		end
		return r;
	endfunction

	sq_t              st_a [N];
	sq_t              st_b [N];
	sq_t              pa   [N];
	sq_t              pb   [N];
	logic [TAG_W-1:0] tag_q [N];
	logic             v_q  [N];

	always_comb begin
		for (int i = 0; i < N; i++) begin
			if (i == 0) begin
				pa[i] = '{rad: in_a, rem: '0, root: '0};
				pb[i] = '{rad: in_b, rem: '0, root: '0};
			end else begin
				pa[i] = st_a[i-1];
				pb[i] = st_b[i-1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < N; i++) begin
				v_q[i] <= 1'b0;
			end
		end else if (adv) begin
			v_q[0] <= in_valid;
			for (int i = 1; i < N; i++) begin
				v_q[i] <= v_q[i-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tag_q[0] <= in_tag;
			for (int i = 1; i < N; i++) begin
				tag_q[i] <= tag_q[i-1];
			end
			for (int i = 0; i < N; i++) begin
				st_a[i] <= sqrt_step(pa[i]);
				st_b[i] <= sqrt_step(pb[i]);
			end
		end
	end

	assign out_valid = v_q[N-1];
	assign out_ra    = st_a[N-1].root;
	assign out_rb    = st_b[N-1].root;
	assign out_tag   = tag_q[N-1];

endmodule
`default_nettype wire

// ----- sv/gvq_back.sv -----
// Back end: velocity store, read sequencer, difference terms, curl and Q
// arithmetic, square root and the output register. Depends on gvq_pkg, gvq_sqrt.
`default_nettype none
module gvq_back #(
	parameter int GRID_SIDE = 32,
	parameter int VEL_BITS  = 16
) (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire gvq_pkg::cfg_t                cfg,
	input  wire                               head_valid,
	input  wire  [gvq_pkg::KIND_W+$clog2(GRID_SIDE*GRID_SIDE*GRID_SIDE)+3*VEL_BITS-1:0] head_data,
	output logic                              pop,
	output logic                              out_valid,
	input  wire                               out_stall,
	output logic                              at_border,
	output logic [gvq_pkg::VORT_W-1:0]        vorticity,
	output logic signed [gvq_pkg::Q_W-1:0]    q_value
);

	localparam int G     = GRID_SIDE;
	localparam int VB    = VEL_BITS;
	localparam int DEPTH = G * G * G;
	localparam int AW    = $clog2(DEPTH);
	localparam int KW    = gvq_pkg::KIND_W;
	localparam int EW    = KW + AW + 3 * VB;
	localparam int TW    = VB + 17;
	localparam int CW    = TW + 1;
	localparam int MW    = (CW > 33) ? CW : 33;
	localparam int PW    = 2 * TW - 16;
	localparam int SUMW  = PW + 3;
	localparam int NW    = (PW + 5 > 50) ? PW + 5 : 50;
	localparam int QW    = gvq_pkg::Q_W;
	localparam logic [2:0] STEP_CTR  = 3'd0;
	localparam logic [2:0] STEP_LAST = 3'd6;
	localparam logic [AW-1:0] OFF_X = AW'(1);
	localparam logic [AW-1:0] OFF_Y = AW'(G);
	localparam logic [AW-1:0] OFF_Z = AW'(G * G);
	localparam logic signed [NW-1:0] QMAX = NW'((64'sd1 <<< (QW - 1)) - 64'sd1);
	localparam logic signed [NW-1:0] QMIN = -QMAX - NW'(1);

	logic                 adv, start, rd_start, rd_en, mem_we, brd_start;
	logic [KW-1:0]        h_kind;
	logic [AW-1:0]        h_addr, nb_addr, mem_addr, base_q;
	logic [3*VB-1:0]      h_vel;
	logic                 busy_q;
	logic [2:0]           step_q, step_rd;
	logic [3*VB-1:0]      mem [DEPTH];

	logic                 valid_s1, brd_s1;
	logic [2:0]           step_s1, ridx;
	logic [3*VB-1:0]      dout_s1, cent_q;
	logic [gvq_pkg::INV_W-1:0] inv_sel;
	logic signed [VB:0]   diff [3];
	logic signed [VB+17:0] prod [3];
	logic signed [TW-1:0] rows_q [6][3];

	logic                 valid_s2, brd_s2;
	logic                 valid_s3, brd_s3;
	logic signed [CW-1:0] curl_s3 [6];
	logic signed [TW-1:0] t_s3 [6][3];

	logic [MW-1:0]        mg [6];
	logic signed [2*TW-1:0] pd [6];
	logic signed [2*TW-1:0] po [6];
	logic                 valid_s4, brd_s4;
	logic [63:0]          sq_s4 [6];
	logic                 sat_s4 [6];
	logic signed [PW-1:0] dg_s4 [6];
	logic signed [PW-1:0] of_s4 [6];

	logic [63:0]          csum [2];
	logic signed [SUMW-1:0] s_sum, p_sum;
	logic                 valid_s5, brd_s5;
	logic [63:0]          csum_s5 [2];
	logic signed [SUMW-1:0] s_s5, p_s5;

	logic signed [NW-1:0] num, qv;
	logic                 valid_s6, brd_s6;
	logic [63:0]          csum_s6 [2];
	logic signed [QW-1:0] q_s6;

	logic                 sq_valid;
	logic [31:0]          ra, rb;
	logic [QW:0]          sq_tag;
	logic [32:0]          vsum;
	logic                 out_valid_q, at_border_q;
	logic [31:0]          vort_q;
	logic signed [QW-1:0] q_q;

	// hold the whole back end while a result waits
	assign adv = !out_valid_q || !out_stall;

	assign h_kind = head_data[EW-1 -: KW];
	assign h_addr = head_data[3*VB +: AW];
	assign h_vel  = head_data[3*VB-1:0];

	assign start     = adv && head_valid && !busy_q;
	assign pop       = start;
	assign mem_we    = start && (h_kind == gvq_pkg::KIND_WR);
	assign rd_start  = start && (h_kind == gvq_pkg::KIND_QRY);
	assign brd_start = start && (h_kind == gvq_pkg::KIND_BRD);
	assign rd_en     = rd_start || (adv && busy_q);
	assign step_rd   = busy_q ? step_q : STEP_CTR;

	always_comb begin
		case (step_q)
			3'd1:    nb_addr = base_q + OFF_X;
			3'd2:    nb_addr = base_q + OFF_Y;
			3'd3:    nb_addr = base_q + OFF_Z;
			3'd4:    nb_addr = base_q - OFF_X;
			3'd5:    nb_addr = base_q - OFF_Y;
			3'd6:    nb_addr = base_q - OFF_Z;
			default: nb_addr = base_q;
		endcase
		mem_addr = busy_q ? nb_addr : h_addr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			step_q   <= STEP_CTR;
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			if (rd_start) begin
				busy_q <= 1'b1;
				step_q <= 3'd1;
			end else if (busy_q) begin
				if (step_q == STEP_LAST) begin
					busy_q <= 1'b0;
				end
				step_q <= step_q + 3'd1;
			end
			valid_s1 <= rd_en || brd_start;
			valid_s2 <= valid_s1 && (brd_s1 || (step_s1 == STEP_LAST));
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
			valid_s6 <= valid_s5;
			out_valid_q <= sq_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_addr] <= h_vel;
		end
		if (rd_en) begin
			dout_s1 <= mem[mem_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (rd_start) begin
			base_q <= h_addr;
		end
		if (adv) begin
			brd_s1  <= !rd_en;
			step_s1 <= step_rd;
		end
	end

	// difference terms for the neighbor just read
	always_comb begin
		ridx = step_s1 - 3'd1;
		case (step_s1)
			3'd1, 3'd4: inv_sel = cfg.inv_x;
			3'd2, 3'd5: inv_sel = cfg.inv_y;
			default:    inv_sel = cfg.inv_z;
		endcase
		for (int c = 0; c < 3; c++) begin
			diff[c] = (VB+1)'($signed(dout_s1[c*VB +: VB])) -
			          (VB+1)'($signed(cent_q[c*VB +: VB]));
			prod[c] = diff[c] * $signed({1'b0, inv_sel});
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s1 && !brd_s1) begin
			if (step_s1 == STEP_CTR) begin
				cent_q <= dout_s1;
			end else begin
				for (int c = 0; c < 3; c++) begin
					rows_q[ridx][c] <= TW'(prod[c]);
				end
			end
		end
	end

	always_comb begin
		logic signed [MW-1:0] cx;
		cx = '0;
		for (int k = 0; k < 6; k++) begin
			cx    = MW'(curl_s3[k]);
			mg[k] = cx[MW-1] ? MW'(-cx) : MW'(cx);
		end
		for (int s = 0; s < 2; s++) begin
			for (int n = 0; n < 3; n++) begin
				pd[s*3+n] = t_s3[s*3+n][n] * t_s3[s*3+n][n];
			end
			po[s*3+0] = t_s3[s*3+1][2] * t_s3[s*3+2][1];
			po[s*3+1] = t_s3[s*3+2][0] * t_s3[s*3+0][2];
			po[s*3+2] = t_s3[s*3+0][1] * t_s3[s*3+1][0];
		end
	end

	always_comb begin
		logic [65:0] acc;
		logic        anysat;
		acc    = '0;
		anysat = 1'b0;
		s_sum  = '0;
		p_sum  = '0;
		for (int s = 0; s < 2; s++) begin
			acc    = {2'b00, sq_s4[s*3]} + {2'b00, sq_s4[s*3+1]} + {2'b00, sq_s4[s*3+2]};
			anysat = sat_s4[s*3] || sat_s4[s*3+1] || sat_s4[s*3+2] || (acc[65:64] != 2'b00);
			csum[s] = anysat ? '1 : acc[63:0];
		end
		for (int k = 0; k < 6; k++) begin
			s_sum = s_sum + SUMW'(dg_s4[k]);
			p_sum = p_sum + SUMW'(of_s4[k]);
		end
		num = -NW'(s_s5) - (NW'(p_s5) <<< 1);
		qv  = num >>> 2;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			brd_s2 <= brd_s1;
			brd_s3 <= brd_s2;
			for (int s = 0; s < 2; s++) begin
				curl_s3[s*3+0] <= CW'(rows_q[s*3+1][2]) - CW'(rows_q[s*3+2][1]);
				curl_s3[s*3+1] <= CW'(rows_q[s*3+2][0]) - CW'(rows_q[s*3+0][2]);
				curl_s3[s*3+2] <= CW'(rows_q[s*3+0][1]) - CW'(rows_q[s*3+1][0]);
			end
			t_s3 <= rows_q;
			brd_s4 <= brd_s3;
			for (int k = 0; k < 6; k++) begin
				sq_s4[k]  <= mg[k][31:0] * mg[k][31:0];
				sat_s4[k] <= |mg[k][MW-1:32];
				dg_s4[k]  <= pd[k][2*TW-1:16];
				of_s4[k]  <= po[k][2*TW-1:16];
			end
			brd_s5  <= brd_s4;
			csum_s5 <= csum;
			s_s5    <= s_sum;
			p_s5    <= p_sum;
			brd_s6  <= brd_s5;
			csum_s6 <= csum_s5;
			if (qv > QMAX) begin
				q_s6 <= QW'(QMAX);
			end else if (qv < QMIN) begin
				q_s6 <= QW'(QMIN);
			end else begin
				q_s6 <= QW'(qv);
			end
		end
	end

	gvq_sqrt #(
		.TAG_W(QW + 1)
	) u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_valid (valid_s6),
		.in_a     (csum_s6[0]),
		.in_b     (csum_s6[1]),
		.in_tag   ({brd_s6, q_s6}),
		.out_valid(sq_valid),
		.out_ra   (ra),
		.out_rb   (rb),
		.out_tag  (sq_tag)
	);

	assign vsum = {1'b0, ra} + {1'b0, rb};

	always_ff @(posedge clk) begin
		if (adv) begin
			at_border_q <= sq_tag[QW];
			vort_q      <= sq_tag[QW] ? '0 : vsum[32:1];
			q_q         <= sq_tag[QW] ? '0 : $signed(sq_tag[QW-1:0]);
		end
	end

	assign out_valid = out_valid_q;
	assign at_border = at_border_q;
	assign vorticity = vort_q;
	assign q_value   = q_q;

endmodule
`default_nettype wire
